/* rtl/u2u8_pkg.sv */
package u2u8_pkg;

  // Field widths
  localparam int UnitW  = 16;
  localparam int LimitW = 16;
  localparam int CountW = 17;
  localparam int CpW    = 21;
  localparam int LenW   = 3;
  localparam int IdxW   = 3;

  // Job queue between front and back
  localparam int QDepth = 2;
  localparam int QAw    = $clog2(QDepth);

  localparam logic [LimitW-1:0] LimitReset = 16'hFFFF;

  // Surrogate handling
  localparam logic [UnitW-1:0] SurrMask  = 16'hFC00;
  localparam logic [UnitW-1:0] HighSurr  = 16'hD800;
  localparam logic [31:0]      LowBase   = 32'h0000_DC00;
  localparam logic [31:0]      SuppBase  = 32'h0001_0000;

  // Code point range bounds
  localparam logic [31:0] Lim1Byte  = 32'h0000_0080;
  localparam logic [31:0] Lim2Byte  = 32'h0000_0800;
  localparam logic [31:0] Lim3Byte  = 32'h0001_0000;
  localparam logic [31:0] SurrLo    = 32'h0000_D800;
  localparam logic [31:0] SurrHi    = 32'h0000_DFFF;
  localparam logic [31:0] MaxCp     = 32'h0010_FFFF;

  // Sequence lengths
  localparam logic [LenW-1:0] Len0 = 3'd0;
  localparam logic [LenW-1:0] Len1 = 3'd1;
  localparam logic [LenW-1:0] Len2 = 3'd2;
  localparam logic [LenW-1:0] Len3 = 3'd3;
  localparam logic [LenW-1:0] Len4 = 3'd4;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             last_unit;
  } unit_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              is_terminator;
    logic              end_of_string;
    logic [CountW-1:0] total_bytes;
  } res_t;

  // One classified unit: the bytes to send and the string-end details
  typedef struct packed {
    logic [CpW-1:0]    cp;
    logic [LenW-1:0]   len;
    logic              term;
    logic              eos;
    logic [CountW-1:0] total;
  } job_t;

  function automatic logic [LenW-1:0] utf8_len(input logic [31:0] cp);
    logic [LenW-1:0] len;
    if (cp < Lim1Byte) len = Len1;
    else if (cp < Lim2Byte) len = Len2;
    else if (cp < Lim3Byte) len = (cp >= SurrLo && cp <= SurrHi) ? Len0 : Len3;
    else if (cp <= MaxCp) len = Len4;
    else len = Len0;
    return len;
  endfunction

  // Byte idx of the UTF-8 sequence of cp
  function automatic logic [7:0] utf8_byte(input logic [CpW-1:0] cp,
                                           input logic [LenW-1:0] len,
                                           input logic [IdxW-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (len)
      Len1: b = cp[7:0];
      Len2: begin
        case (idx)
          3'd0: b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      Len3: begin
        case (idx)
          3'd0: b = {4'b1110, cp[15:12]};
          3'd1: b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      Len4: begin
        case (idx)
          3'd0: b = {5'b11110, cp[20:18]};
          3'd1: b = {2'b10, cp[17:12]};
          3'd2: b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/utf16_to_utf8_stream_unit.sv */
// Channel  Handshake                Payload
// unit     unit_valid / unit_stall  unit_data: code_unit, last_unit
// res      res_valid / res_stall    res_data: out_byte, byte_valid, is_terminator,
//                                             end_of_string, total_bytes
// cfg      cfg_we                   cfg_data: out_limit
//
// The front takes one code unit per cycle unless unit_stall is high; the back sends
// one result beat per cycle unless res_stall is high. A unit makes up to 5 beats
// (4 bytes plus NUL); units that are not queued make none.
// Synchronous reset clears string state, the two-entry job queue and the output
// register, and sets out_limit to 65535. A held res_stall fills the queue, then
// raises unit_stall.
module utf16_to_utf8_stream_unit import u2u8_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              unit_valid,
  output logic              unit_stall,
  input  unit_t             unit_data,
  output logic              res_valid,
  input  logic              res_stall,
  output res_t              res_data,
  input  logic              cfg_we,
  input  logic [LimitW-1:0] cfg_data
);

  logic push;
  job_t push_job;
  logic pop;
  logic full;
  logic head_valid;
  job_t head_job;

  assign unit_stall = full;

  u2u8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .take     (unit_valid && !unit_stall),
    .unit     (unit_data),
    .push     (push),
    .job      (push_job)
  );

  u2u8_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  u2u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
  );

endmodule

/* rtl/u2u8_front.sv */
module u2u8_front import u2u8_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [LimitW-1:0] cfg_data,
  input  logic              take,
  input  unit_t             unit,
  output logic              push,
  output job_t              job
);

  logic              pending_valid;
  logic [9:0]        pending_high;
  logic [CountW-1:0] byte_count;
  logic [LimitW-1:0] out_limit;

  logic              pending_valid_next;
  logic [9:0]        pending_high_next;
  logic [CountW-1:0] byte_count_next;

  logic [31:0]       low_diff;
  logic [31:0]       cp32;
  logic              have;
  logic              hold;
  logic [LenW-1:0]   len;
  logic [CountW-1:0] count_new;
  logic              lim_zero;

  // Surrogate pair arithmetic, 32-bit wrap as specified
  assign low_diff = {16'b0, unit.code_unit} - LowBase;

  // Classify the unit and work out the new count
  always_comb begin
    lim_zero = (out_limit == '0);
    hold     = 1'b0;
    have     = 1'b0;
    cp32     = {16'b0, unit.code_unit};
    if (pending_valid) begin
      cp32 = (({22'b0, pending_high} << 10) | low_diff) + SuppBase;
      have = 1'b1;
    end else if (byte_count >= {1'b0, out_limit}) begin
      have = 1'b0;
    end else if ((unit.code_unit & SurrMask) == HighSurr && !unit.last_unit) begin
      hold = 1'b1;
    end else begin
      have = 1'b1;
    end
    len       = have ? utf8_len(cp32) : Len0;
    count_new = byte_count + {{(CountW-LenW){1'b0}}, len};

    job.cp    = cp32[CpW-1:0];
    job.len   = len;
    job.term  = unit.last_unit && (count_new < {1'b0, out_limit});
    job.eos   = unit.last_unit;
    job.total = count_new;
    push      = take && !lim_zero && (len != Len0 || unit.last_unit);

    pending_valid_next = pending_valid;
    pending_high_next  = pending_high;
    byte_count_next    = byte_count;
    if (take) begin
      if (unit.last_unit) begin
        pending_valid_next = 1'b0;
        pending_high_next  = '0;
        byte_count_next    = '0;
      end else if (!lim_zero) begin
        pending_valid_next = hold;
        pending_high_next  = hold ? unit.code_unit[9:0] : '0;
        byte_count_next    = count_new;
      end
    end
  end

  // String state and limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
      pending_high  <= '0;
      byte_count    <= '0;
      out_limit     <= LimitReset;
    end else begin
      pending_valid <= pending_valid_next;
      pending_high  <= pending_high_next;
      byte_count    <= byte_count_next;
      if (cfg_we) out_limit <= cfg_data;
    end
  end

endmodule

/* rtl/u2u8_queue.sv */
module u2u8_queue import u2u8_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  job_t           mem [QDepth];
  logic [QAw-1:0] wr_ptr;
  logic [QAw-1:0] rd_ptr;
  logic [QAw:0]   count;

  assign full       = (count == QDepth[QAw:0]);
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("job queue underflow");

endmodule

/* rtl/u2u8_back.sv */
module u2u8_back import u2u8_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  job_t head_job,
  output logic pop,
  output logic res_valid,
  input  logic res_stall,
  output res_t res_data
);

  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] n_res;
  logic            last_res;
  logic            load;
  res_t            res_next;

  // Results in this job: bytes, optional NUL, or one empty beat
  always_comb begin
    n_res = head_job.len + {2'b0, head_job.term}
          + {2'b0, (head_job.len == Len0 && !head_job.term)};
    last_res = (idx == n_res - 1'b1);
    load     = head_valid && (!res_valid || !res_stall);
    pop      = load && last_res;

    res_next = '0;
    if (idx < head_job.len) begin
      res_next.out_byte   = utf8_byte(head_job.cp, head_job.len, idx);
      res_next.byte_valid = 1'b1;
    end else if (head_job.term) begin
      res_next.byte_valid    = 1'b1;
      res_next.is_terminator = 1'b1;
    end
    if (last_res && head_job.eos) begin
      res_next.end_of_string = 1'b1;
      res_next.total_bytes   = head_job.total;
    end
  end

  // Output register and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      res_valid <= 1'b1;
      idx       <= last_res ? '0 : idx + 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_data <= res_next;
  end

  a_total_only_at_end: assert property (@(posedge clk) disable iff (rst)
      res_valid && !res_data.end_of_string |-> res_data.total_bytes == '0)
    else $error("total set on a non-final beat");
  a_nul_is_zero: assert property (@(posedge clk) disable iff (rst)
      res_valid && res_data.is_terminator |-> res_data.byte_valid && res_data.out_byte == 8'h00)
    else $error("terminator beat malformed");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
      head_valid |-> idx < n_res)
    else $error("byte index beyond job length");

endmodule

/* bench/testbench.sv */
module testbench;
  import u2u8_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 16;

  // Directed rows: a code unit, or a write of out_limit
  typedef enum logic {ROW_UNIT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [UnitW-1:0]  val;
    logic              lst;
    logic              typed;    // beats below replace the prediction
    logic              typed_n;  // 0: no beat, 1: exactly the beat below
    res_t              beat;
  } row_t;

  localparam res_t NoBeat = '0;

  logic              clk;
  logic              rst;
  logic              unit_valid;
  logic              unit_stall;
  unit_t             unit_data;
  logic              res_valid;
  logic              res_stall;
  res_t              res_data;
  logic              cfg_we;
  logic [LimitW-1:0] cfg_data;

  // Converter state as the bench sees it
  logic              held_valid;
  logic [9:0]        held_high;
  logic [CountW-1:0] bytes_out;
  logic [LimitW-1:0] cap;

  res_t fresh_beats[$];  // beats of the unit just taken
  res_t beats_due[$];    // beats still owed by the block

  int src_idle_pct;
  int snk_stall_pct;
  int err_count;
  int cycle_cnt;

  row_t dir_rows [28] = '{
    '{ROW_UNIT, 16'h0041, 1'b0, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b0, 1'b0, 17'd0}},
    '{ROW_UNIT, 16'h0000, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 17'd0}},
    '{ROW_UNIT, 16'h007F, 1'b0, 1'b1, 1'b1, '{8'h7F, 1'b1, 1'b0, 1'b0, 17'd0}},
    '{ROW_UNIT, 16'h0080, 1'b0, 1'b0, 1'b0, NoBeat},
    '{ROW_UNIT, 16'h07FF, 1'b0, 1'b0, 1'b0, NoBeat},
    '{ROW_UNIT, 16'h0800, 1'b0, 1'b0, 1'b0, NoBeat},
    '{ROW_UNIT, 16'hFFFF, 1'b1, 1'b0, 1'b0, NoBeat},
    // surrogate pairs at both ends of the supplementary range
    '{ROW_UNIT, 16'hD800, 1'b0, 1'b1, 1'b0, NoBeat},
    '{ROW_UNIT, 16'hDC00, 1'b0, 1'b0, 1'b0, NoBeat},
    '{ROW_UNIT, 16'hDBFF, 1'b0, 1'b1, 1'b0, NoBeat},
    '{ROW_UNIT, 16'hDFFF, 1'b0, 1'b0, 1'b0, NoBeat},
    // high surrogate followed by a non-low unit: combined anyway
    '{ROW_UNIT, 16'hD83D, 1'b0, 1'b1, 1'b0, NoBeat},
    '{ROW_UNIT, 16'h0041, 1'b1, 1'b0, 1'b0, NoBeat},
    // lone low surrogate, and a high surrogate as the last unit
    '{ROW_UNIT, 16'hDC00, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 17'd0}},
    '{ROW_UNIT, 16'hDBFF, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 17'd0}},
    // zero limit: silence
    '{ROW_CFG,  16'h0000, 1'b0, 1'b0, 1'b0, NoBeat},
    '{ROW_UNIT, 16'h0042, 1'b0, 1'b1, 1'b0, NoBeat},
    '{ROW_UNIT, 16'hD800, 1'b1, 1'b1, 1'b0, NoBeat},
    // limit of one: overshoot, then a dropped unit ends in an empty beat
    '{ROW_CFG,  16'h0001, 1'b0, 1'b0, 1'b0, NoBeat},
    '{ROW_UNIT, 16'h0800, 1'b0, 1'b0, 1'b0, NoBeat},
    '{ROW_UNIT, 16'h0041, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 17'd3}},
    // held surrogate survives a lowered limit
    '{ROW_CFG,  16'h0003, 1'b0, 1'b0, 1'b0, NoBeat},
    '{ROW_UNIT, 16'h0041, 1'b0, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b0, 1'b0, 17'd0}},
    '{ROW_UNIT, 16'h0042, 1'b0, 1'b1, 1'b1, '{8'h42, 1'b1, 1'b0, 1'b0, 17'd0}},
    '{ROW_UNIT, 16'hD800, 1'b0, 1'b1, 1'b0, NoBeat},
    '{ROW_CFG,  16'h0001, 1'b0, 1'b0, 1'b0, NoBeat},
    '{ROW_UNIT, 16'hDC00, 1'b1, 1'b0, 1'b0, NoBeat},
    '{ROW_CFG,  16'hFFFF, 1'b0, 1'b0, 1'b0, NoBeat}
  };

  utf16_to_utf8_stream_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_data  (unit_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Work out the UTF-8 beats of one code unit and advance the string state
  function automatic void encode_unit(input logic [UnitW-1:0] cu, input logic lst);
    logic [31:0] cp;
    logic [31:0] v;
    logic        have;
    int          len;
    logic [7:0]  seq [4];
    res_t        beat;
    fresh_beats.delete();
    if (cap == '0) begin
      if (lst) begin
        held_valid = 1'b0;
        held_high  = '0;
        bytes_out  = '0;
      end
      return;
    end
    have = 1'b0;
    cp   = '0;
    len  = 0;
    if (held_valid) begin
      cp = (32'(held_high) << 10) | (32'(cu) - LowBase);
      cp = cp + SuppBase;
      held_valid = 1'b0;
      held_high  = '0;
      have = 1'b1;
    end else if (bytes_out >= CountW'(cap)) begin
      have = 1'b0;
    end else if ((cu & SurrMask) == HighSurr && !lst) begin
      held_valid = 1'b1;
      held_high  = cu[9:0];
    end else begin
      cp = 32'(cu);
      have = 1'b1;
    end
    if (have) begin
      if (cp > MaxCp) len = 0;
      else if (cp >= Lim3Byte) len = 4;
      else if (cp >= SurrLo && cp <= SurrHi) len = 0;
      else if (cp >= Lim2Byte) len = 3;
      else if (cp >= Lim1Byte) len = 2;
      else len = 1;
      v = cp;
      for (int i = len - 1; i > 0; i--) begin
        seq[i] = {2'b10, v[5:0]};
        v = v >> 6;
      end
      case (len)
        1: seq[0] = v[7:0];
        2: seq[0] = 8'hC0 | v[7:0];
        3: seq[0] = 8'hE0 | v[7:0];
        4: seq[0] = 8'hF0 | v[7:0];
        default: ;
      endcase
      for (int i = 0; i < len; i++) begin
        beat = '0;
        beat.out_byte   = seq[i];
        beat.byte_valid = 1'b1;
        fresh_beats.push_back(beat);
      end
      bytes_out = bytes_out + CountW'(len);
    end
    if (lst) begin
      if (bytes_out < CountW'(cap)) begin
        beat = '0;
        beat.byte_valid    = 1'b1;
        beat.is_terminator = 1'b1;
        fresh_beats.push_back(beat);
      end
      if (fresh_beats.size() == 0) fresh_beats.push_back(NoBeat);
      beat = fresh_beats.pop_back();
      beat.end_of_string = 1'b1;
      beat.total_bytes   = bytes_out;
      fresh_beats.push_back(beat);
      bytes_out  = '0;
      held_valid = 1'b0;
      held_high  = '0;
    end
  endfunction

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Offer one code unit, wait for the unit to be taken, then book its results
  task automatic send_unit(input logic [UnitW-1:0] cu, input logic lst,
                           input logic typed, input logic typed_n, input res_t typed_beat);
    while ($urandom_range(99) < src_idle_pct) begin
      unit_valid <= 1'b0;
      @(negedge clk);
    end
    unit_valid <= 1'b1;
    unit_data  <= unit_t'{cu, lst};
    do @(posedge clk); while (unit_stall);
    encode_unit(cu, lst);
    if (typed) begin
      if (typed_n) beats_due.push_back(typed_beat);
    end else begin
      foreach (fresh_beats[i]) beats_due.push_back(fresh_beats[i]);
    end
    @(negedge clk);
  endtask

  // Write out_limit once the block has gone quiet
  task automatic set_limit(input logic [LimitW-1:0] lim);
    unit_valid <= 1'b0;
    while (beats_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= lim;
    @(negedge clk);
    cfg_we <= 1'b0;
    cap = lim;
  endtask

  // One random string, mostly well-formed text with some broken surrogates
  task automatic send_string(input int n_units);
    logic [UnitW-1:0] units[$];
    int               pick;
    while (units.size() < n_units) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        units.push_back(UnitW'($urandom_range(0, 16'h007F)));
      end else if (pick < 45) begin
        units.push_back(UnitW'($urandom_range(16'h0080, 16'h07FF)));
      end else if (pick < 60) begin
        units.push_back(UnitW'($urandom_range(16'h0800, 16'hFFFF)));
      end else if (pick < 80 && units.size() + 2 <= n_units) begin
        units.push_back(HighSurr | UnitW'($urandom_range(0, 1023)));
        units.push_back(16'hDC00 | UnitW'($urandom_range(0, 1023)));
      end else if (pick < 88) begin
        units.push_back(UnitW'($urandom_range(16'hD800, 16'hDFFF)));
      end else begin
        units.push_back(UnitW'($urandom));
      end
    end
    foreach (units[i]) send_unit(units[i], i == units.size() - 1, 1'b0, 1'b0, NoBeat);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < snk_stall_pct);
  end

  // Compare each taken beat with the oldest one owed
  always @(posedge clk) begin : check_beats
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (beats_due.size() == 0) begin
        report($sformatf("unexpected beat, byte %02h", res_data.out_byte));
      end else begin
        want = beats_due.pop_front();
        check_field("out_byte", 32'(res_data.out_byte), 32'(want.out_byte));
        check_field("byte_valid", 32'(res_data.byte_valid), 32'(want.byte_valid));
        check_field("is_terminator", 32'(res_data.is_terminator),
                    32'(want.is_terminator));
        check_field("end_of_string", 32'(res_data.end_of_string),
                    32'(want.end_of_string));
        check_field("total_bytes", 32'(res_data.total_bytes), 32'(want.total_bytes));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    int               sent;
    int               budget;
    int               n;
    logic [LimitW-1:0] lim;
    rst        = 1'b1;
    unit_valid = 1'b0;
    unit_data  = '0;
    res_stall  = 1'b0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    err_count  = 0;
    cycle_cnt  = 0;
    held_valid = 1'b0;
    held_high  = '0;
    bytes_out  = '0;
    cap        = LimitReset;
    src_idle_pct  = 7;
    snk_stall_pct = 67;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        set_limit(dir_rows[i].val);
      end else begin
        send_unit(dir_rows[i].val, dir_rows[i].lst, dir_rows[i].typed,
                  dir_rows[i].typed_n, dir_rows[i].beat);
      end
    end

    // Random strings: three idling regimes, two limit settings each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle_pct = 7;  snk_stall_pct = 67; end
        1: begin src_idle_pct = 67; snk_stall_pct = 7;  end
        default: begin src_idle_pct = 0; snk_stall_pct = 0; end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        case (ph * 2 + seg)
          0: lim = LimitReset;
          1: lim = LimitW'($urandom_range(2, 12));
          2: lim = 16'd1;
          3: lim = LimitW'($urandom_range(13, 80));
          4: lim = '0;
          default: lim = LimitW'($urandom_range(81, 65534));
        endcase
        set_limit(lim);
        budget = (lim == '0) ? 15 : 62;
        sent = 0;
        while (sent < budget) begin
          n = $urandom_range(1, 10);
          send_string(n);
          sent += n;
        end
      end
    end

    // Drain
    unit_valid <= 1'b0;
    while (beats_due.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (err_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
